// ----- src/set_assoc_lru_cache_next_line_prefetch_top_assert.svh -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_next_line_prefetch_top_assert.svh
// assertion macros for the cache with next-line prefetch
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_NEXT_LINE_PREFETCH_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_NEXT_LINE_PREFETCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SALPF_AST_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("salpf assertion failed");
// next-cycle implication
`define SALPF_AST_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("salpf assertion failed");
`else
`define SALPF_AST_IMP(lbl, clk, rstn, ante, cons)
`define SALPF_AST_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/salpf_pkg.sv -----
// ----------------------------------------------------------------------------
// salpf_pkg
// shared types and constants of the cache with next-line prefetch
// ----------------------------------------------------------------------------
`default_nettype none
package salpf_pkg;
	localparam int FETCH_W = 32;
	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// outcome of one set lookup and what must be written back
	typedef struct packed {
		logic hit;
		logic marked;
		logic write_meta;
		logic write_tag;
	} look_t;
endpackage
`default_nettype wire

// ----- src/salpf_set_store.sv -----
// ----------------------------------------------------------------------------
// salpf_set_store
// per-set rows of line state (valid, mark, age) and tags, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module salpf_set_store #(
	parameter int SET_W = 8,
	parameter int META_W = 16,
	parameter int TROW_W = 76
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [SET_W-1:0]  rd_set,
	output logic      [META_W-1:0] meta_rd,
	output logic      [TROW_W-1:0] tag_rd,
	input  wire logic [SET_W-1:0]  wr_set,
	input  wire logic              meta_we,
	input  wire logic [META_W-1:0] meta_wd,
	input  wire logic              tag_we,
	input  wire logic [TROW_W-1:0] tag_wd
);
	localparam int DEPTH = 1 << SET_W;

	logic [META_W-1:0] meta_mem [DEPTH];
	logic [TROW_W-1:0] tag_mem [DEPTH];
	logic [META_W-1:0] meta_rd_q;
	logic [TROW_W-1:0] tag_rd_q;

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[wr_set] <= meta_wd;
		end
		if (tag_we) begin
			tag_mem[wr_set] <= tag_wd;
		end
		if (rd_en) begin
			meta_rd_q <= meta_mem[rd_set];
			tag_rd_q <= tag_mem[rd_set];
		end
	end

	assign meta_rd = meta_rd_q;
	assign tag_rd = tag_rd_q;
endmodule
`default_nettype wire

// ----- src/salpf_way_update.sv -----
// ----------------------------------------------------------------------------
// salpf_way_update
// tag match, victim choice and lru promotion for one set row
// ----------------------------------------------------------------------------
`default_nettype none
module salpf_way_update #(
	parameter int WAYS = 4,
	parameter int AGE_W = 2,
	parameter int WAY_W = 2,
	parameter int TAG_W = 19
) (
	input  wire logic                        prefetch,
	input  wire logic [TAG_W-1:0]            req_tag,
	input  wire logic [WAYS-1:0]             valid,
	input  wire logic [WAYS-1:0]             mark,
	input  wire logic [WAYS-1:0][AGE_W-1:0]  age,
	input  wire logic [WAYS-1:0][TAG_W-1:0]  tags,
	output logic      [WAYS-1:0]             new_valid,
	output logic      [WAYS-1:0]             new_mark,
	output logic      [WAYS-1:0][AGE_W-1:0]  new_age,
	output logic      [WAYS-1:0][TAG_W-1:0]  new_tags,
	output salpf_pkg::look_t                 status
);
	logic             hit_f;
	logic [WAY_W-1:0] hit_way;
	logic             any_inv;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] age0_way;
	logic [WAY_W-1:0] sel;
	logic [AGE_W-1:0] mine;
	logic             upd;

	always_comb begin
		hit_f = 1'b0;
		hit_way = '0;
		any_inv = 1'b0;
		inv_way = '0;
		age0_way = '0;
		// descending so the lowest matching / empty way wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid[w] && (tags[w] == req_tag)) begin
				hit_f = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid[w]) begin
				any_inv = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
		// last age-zero way, way 0 if none
		for (int w = 0; w < WAYS; w++) begin
			if (age[w] == '0) begin
				age0_way = WAY_W'(w);
			end
		end
		sel = hit_f ? hit_way : (any_inv ? inv_way : age0_way);
		mine = age[sel];
		// a prefetch of a block already held leaves the set alone
		upd = !(prefetch && hit_f);

		new_valid = valid;
		new_mark = mark;
		new_age = age;
		new_tags = tags;
		if (upd) begin
			for (int w = 0; w < WAYS; w++) begin
				if (age[w] > mine) begin
					new_age[w] = age[w] - AGE_W'(1);
				end
			end
			new_age[sel] = AGE_W'(WAYS - 1);
			new_valid[sel] = 1'b1;
			new_mark[sel] = prefetch;
			if (!hit_f) begin
				new_tags[sel] = req_tag;
			end
		end

		status.hit = hit_f;
		status.marked = hit_f && mark[hit_way];
		status.write_meta = upd;
		status.write_tag = !hit_f;
	end
endmodule
`default_nettype wire

// ----- src/set_assoc_lru_cache_next_line_prefetch_top.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_next_line_prefetch_top
// tag-only set-associative cache with lru ages and next-line prefetch
//
// channel  ports                                   timing
// in       start, busy, fetch_address              taken when start & !busy
// out      done, hit, prefetch_useful, *_total     done one-cycle strobe, no stall
//
// a hit makes one read-modify-write pass through the set store for the demand set,
// and a miss a second pass for the next-block set.
// the result word is registered: it appears in the cycle after a hit pass, or
// after the prefetch pass.
// after reset the line state store is cleared one set per cycle with busy high.
// the result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_lru_cache_next_line_prefetch_top_assert.svh"
module set_assoc_lru_cache_next_line_prefetch_top #(
	parameter int CACHE_BYTES = 32768,
	parameter int WAYS = 4,
	parameter int BLOCK_BYTES = 32,
	parameter int ADDR_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [salpf_pkg::FETCH_W-1:0]       fetch_address,
	output logic                                     done,
	output logic                                     hit,
	output logic                                     prefetch_useful,
	output logic      [salpf_pkg::CNT_W-1:0]         miss_total,
	output logic      [salpf_pkg::CNT_W-1:0]         prefetch_success_total,
	output logic      [salpf_pkg::CNT_W-1:0]         prefetch_issue_total
);
	localparam int RAW_SETS = CACHE_BYTES / (BLOCK_BYTES * WAYS);
	localparam int SETS = (RAW_SETS > 0) ? RAW_SETS : 1;
	localparam int OB = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int IB = $clog2(SETS + 1) - 1;
	localparam int SET_W = (IB > 0) ? IB : 1;
	localparam int TAG_SH = OB + IB;
	localparam int TAG_W = (ADDR_BITS > TAG_SH) ? (ADDR_BITS - TAG_SH) : 1;
	localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAY_W = AGE_W;
	localparam int META_W = WAYS * (2 + AGE_W);
	localparam int TROW_W = WAYS * TAG_W;
	localparam int EXT_W = ADDR_BITS + SET_W;
	localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << IB) - 1);
	localparam logic [SET_W-1:0] LAST_SET = SET_W'((1 << IB) - 1);
	localparam logic [ADDR_BITS-1:0] BLOCK_STEP = ADDR_BITS'(1) << OB;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_PF
	} state_t;

	function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] a);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(a) >> OB;
		return ext[SET_W-1:0] & SET_MASK;
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_BITS-1:0] a);
		logic [ADDR_BITS-1:0] sh;
		sh = a >> TAG_SH;
		return TAG_W'(sh);
	endfunction

	function automatic logic [salpf_pkg::CNT_W-1:0] sat_inc(
		input logic [salpf_pkg::CNT_W-1:0] v
	);
		return (v == salpf_pkg::CNT_MAX) ? v : v + salpf_pkg::CNT_W'(1);
	endfunction

	state_t state_q;
	logic [SET_W-1:0] clr_q;
	logic done_q;
	logic hit_q;
	logic useful_q;
	logic [salpf_pkg::CNT_W-1:0] miss_q;
	logic [salpf_pkg::CNT_W-1:0] success_q;
	logic [salpf_pkg::CNT_W-1:0] issue_q;

	logic [ADDR_BITS-1:0] addr_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [SET_W-1:0] nset_s2;
	logic [TAG_W-1:0] ntag_s2;
	logic fwd_s2;
	logic [META_W-1:0] fwd_meta_s2;
	logic [TROW_W-1:0] fwd_tag_s2;

	logic accept;
	logic [ADDR_BITS-1:0] addr_in;
	logic [ADDR_BITS-1:0] nblk_addr;
	logic [SET_W-1:0] nset;
	logic [TAG_W-1:0] ntag;

	logic rd_en;
	logic [SET_W-1:0] rd_set;
	logic [META_W-1:0] meta_rd;
	logic [TROW_W-1:0] tag_rd;
	logic [SET_W-1:0] wr_set;
	logic meta_we;
	logic [META_W-1:0] meta_wd;
	logic tag_we;

	logic [META_W-1:0] src_meta;
	logic [TROW_W-1:0] src_tags;
	logic prefetch;
	logic [TAG_W-1:0] req_tag;
	logic [WAYS-1:0] new_valid;
	logic [WAYS-1:0] new_mark;
	logic [WAYS-1:0][AGE_W-1:0] new_age;
	logic [WAYS-1:0][TAG_W-1:0] new_tags;
	logic [META_W-1:0] new_meta;
	salpf_pkg::look_t look;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign addr_in = ADDR_BITS'(fetch_address);
	assign nblk_addr = addr_s1 + BLOCK_STEP;
	assign nset = set_of(nblk_addr);
	assign ntag = tag_of(nblk_addr);

	// prefetch pass sees the demand write-back when both hit the same set
	assign prefetch = (state_q == ST_PF);
	assign src_meta = (prefetch && fwd_s2) ? fwd_meta_s2 : meta_rd;
	assign src_tags = (prefetch && fwd_s2) ? fwd_tag_s2 : tag_rd;
	assign req_tag = prefetch ? ntag_s2 : tag_s1;
	assign new_meta = {new_valid, new_mark, new_age};

	assign rd_en = accept || ((state_q == ST_LOOK) && !look.hit);
	assign rd_set = (state_q == ST_IDLE) ? set_of(addr_in) : nset;

	always_comb begin
		wr_set = set_s1;
		meta_we = 1'b0;
		meta_wd = new_meta;
		tag_we = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_set = clr_q;
				meta_we = 1'b1;
				meta_wd = '0;
			end
			ST_LOOK: begin
				wr_set = set_s1;
				meta_we = look.write_meta;
				tag_we = look.write_tag;
			end
			ST_PF: begin
				wr_set = nset_s2;
				meta_we = look.write_meta;
				tag_we = look.write_tag;
			end
			default: begin
				wr_set = set_s1;
			end
		endcase
	end

	salpf_set_store #(
		.SET_W  (SET_W),
		.META_W (META_W),
		.TROW_W (TROW_W)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_set  (rd_set),
		.meta_rd (meta_rd),
		.tag_rd  (tag_rd),
		.wr_set  (wr_set),
		.meta_we (meta_we),
		.meta_wd (meta_wd),
		.tag_we  (tag_we),
		.tag_wd  (new_tags)
	);

	salpf_way_update #(
		.WAYS  (WAYS),
		.AGE_W (AGE_W),
		.WAY_W (WAY_W),
		.TAG_W (TAG_W)
	) u_way (
		.prefetch  (prefetch),
		.req_tag   (req_tag),
		.valid     (src_meta[META_W-1 -: WAYS]),
		.mark      (src_meta[META_W-WAYS-1 -: WAYS]),
		.age       (src_meta[WAYS*AGE_W-1:0]),
		.tags      (src_tags),
		.new_valid (new_valid),
		.new_mark  (new_mark),
		.new_age   (new_age),
		.new_tags  (new_tags),
		.status    (look)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
			hit_q <= 1'b0;
			useful_q <= 1'b0;
			miss_q <= '0;
			success_q <= '0;
			issue_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == LAST_SET) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_q <= look.hit;
					useful_q <= look.marked;
					if (look.marked) begin
						success_q <= sat_inc(success_q);
					end
					if (look.hit) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						miss_q <= sat_inc(miss_q);
						issue_q <= sat_inc(issue_q);
						state_q <= ST_PF;
					end
				end
				ST_PF: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= addr_in;
			set_s1 <= set_of(addr_in);
			tag_s1 <= tag_of(addr_in);
		end
		if (state_q == ST_LOOK) begin
			nset_s2 <= nset;
			ntag_s2 <= ntag;
			fwd_s2 <= (nset == set_s1);
			fwd_meta_s2 <= new_meta;
			fwd_tag_s2 <= new_tags;
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign prefetch_useful = useful_q;
	assign miss_total = miss_q;
	assign prefetch_success_total = success_q;
	assign prefetch_issue_total = issue_q;

	`SALPF_AST_IMP(a_done_src, clk, arst_n, done, $past(state_q == ST_LOOK || state_q == ST_PF))
	`SALPF_AST_IMP(a_useful_on_hit, clk, arst_n, done && prefetch_useful, hit)
	`SALPF_AST_NEXT(a_miss_to_pf, clk, arst_n, (state_q == ST_LOOK) && !look.hit, state_q == ST_PF)
	`SALPF_AST_IMP(a_issue_tracks_miss, clk, arst_n, 1'b1, prefetch_issue_total == miss_total)
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the lru instruction cache with next-line prefetch, word by word,
// against a predictor of its tag, age and mark state and its three counters
// ----------------------------------------------------------------------------
module tb;
	localparam int FETCH_W = salpf_pkg::FETCH_W;
	localparam int CNT_W = salpf_pkg::CNT_W;
	localparam int CACHE_BYTES = 32768;
	localparam int WAYS = 4;
	localparam int BLOCK_BYTES = 32;
	localparam int SETS = CACHE_BYTES / (BLOCK_BYTES * WAYS);
	localparam int LINES = SETS * WAYS;
	localparam int OFS_W = $clog2(BLOCK_BYTES);
	localparam int IDX_W = $clog2(SETS);
	localparam int TAG_W = FETCH_W - OFS_W - IDX_W;
	localparam int AGE_W = $clog2(WAYS);
	localparam int RANDOM_FETCHES = 1280;
	localparam int CALM_TAIL = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;

	// fill, lru replacement, prefetch of a block already present, wrap at the top
	localparam logic [FETCH_W-1:0] DIRECTED_FETCHES [21] = '{
		32'h0000_0000, 32'h0000_0020, 32'h0000_003C, 32'hFFFF_FFFF, 32'hFFFF_FFE0,
		32'h0000_2020, 32'h0000_2000, 32'h0000_2044,
		32'h0000_20A0, 32'h0000_40A4, 32'h0000_60A8, 32'h0000_80BC, 32'h0000_20A0,
		32'h0000_A0A0, 32'h0000_40A0, 32'h0000_20B0, 32'h0000_A0C4, 32'h0000_20C0,
		32'h7FFF_FFFC, 32'hAAAA_AAAA, 32'h5555_5555
	};

	typedef struct packed {
		logic             hit;
		logic             useful;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] pf_hits;
		logic [CNT_W-1:0] pf_issued;
	} fetch_result_t;

	class fetch_scoreboard;
		logic             line_ok [LINES];
		logic [TAG_W-1:0] line_tg [LINES];
		logic [AGE_W-1:0] line_rank [LINES];
		logic             line_pf [LINES];
		logic [CNT_W-1:0] misses, pf_hits, pf_issued;
		fetch_result_t    outstanding [$];
		int unsigned      errors;

		function new();
			foreach (line_ok[i]) begin
				line_ok[i] = 1'b0;
				line_tg[i] = '0;
				line_rank[i] = '0;
				line_pf[i] = 1'b0;
			end
			misses = '0;
			pf_hits = '0;
			pf_issued = '0;
			errors = 0;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == salpf_pkg::CNT_MAX) ? v : v + 1'b1;
		endfunction

		function int find_way(int set_i, logic [TAG_W-1:0] t);
			for (int w = 0; w < WAYS; w++)
				if (line_ok[set_i*WAYS+w] && line_tg[set_i*WAYS+w] == t)
					return w;
			return -1;
		endfunction

		function void make_recent(int set_i, int way);
			int base;
			logic [AGE_W-1:0] mine;
			base = set_i * WAYS;
			mine = line_rank[base+way];
			for (int w = 0; w < WAYS; w++)
				if (line_rank[base+w] > mine)
					line_rank[base+w] = line_rank[base+w] - 1'b1;
			line_rank[base+way] = AGE_W'(WAYS - 1);
		endfunction

		// first empty way wins, else the last way of age zero
		function void install(int set_i, logic [TAG_W-1:0] t, logic by_prefetch);
			int base, victim;
			bit found;
			base = set_i * WAYS;
			victim = 0;
			found = 0;
			for (int w = 0; w < WAYS; w++) begin
				if (!found) begin
					if (!line_ok[base+w]) begin
						victim = w;
						found = 1;
					end else if (line_rank[base+w] == '0) begin
						victim = w;
					end
				end
			end
			line_ok[base+victim] = 1'b1;
			line_tg[base+victim] = t;
			make_recent(set_i, victim);
			line_pf[base+victim] = by_prefetch;
		endfunction

		function void note_fetch(logic [FETCH_W-1:0] a);
			fetch_result_t r;
			logic [FETCH_W-1:0] nxt;
			int set_i, way;
			set_i = a[OFS_W +: IDX_W];
			way = find_way(set_i, a[FETCH_W-1 -: TAG_W]);
			r.hit = (way >= 0);
			r.useful = 1'b0;
			if (way >= 0) begin
				if (line_pf[set_i*WAYS+way]) begin
					r.useful = 1'b1;
					pf_hits = bump(pf_hits);
				end
				line_pf[set_i*WAYS+way] = 1'b0;
				make_recent(set_i, way);
			end else begin
				misses = bump(misses);
				install(set_i, a[FETCH_W-1 -: TAG_W], 1'b0);
				nxt = a + FETCH_W'(BLOCK_BYTES);
				pf_issued = bump(pf_issued);
				if (find_way(nxt[OFS_W +: IDX_W], nxt[FETCH_W-1 -: TAG_W]) < 0)
					install(nxt[OFS_W +: IDX_W], nxt[FETCH_W-1 -: TAG_W], 1'b1);
			end
			r.misses = misses;
			r.pf_hits = pf_hits;
			r.pf_issued = pf_issued;
			outstanding.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t: fetch check failed: %s", $realtime, msg);
			errors++;
		endtask

		task check_fetch(fetch_result_t got);
			fetch_result_t want;
			if (outstanding.size() == 0) begin
				report("result word with nothing outstanding");
				return;
			end
			want = outstanding.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("hit %b, want %b", got.hit, want.hit));
			if (got.useful !== want.useful)
				report($sformatf("prefetch_useful %b, want %b", got.useful, want.useful));
			if (got.misses !== want.misses)
				report($sformatf("miss_total %0d, want %0d", got.misses, want.misses));
			if (got.pf_hits !== want.pf_hits)
				report($sformatf("prefetch_success_total %0d, want %0d",
					got.pf_hits, want.pf_hits));
			if (got.pf_issued !== want.pf_issued)
				report($sformatf("prefetch_issue_total %0d, want %0d",
					got.pf_issued, want.pf_issued));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [FETCH_W-1:0] fetch_address = '0;
	logic               busy, done, hit, prefetch_useful;
	logic [CNT_W-1:0]   miss_total, prefetch_success_total, prefetch_issue_total;

	fetch_scoreboard    fetch_board;
	int unsigned        quiet_cycles = 0;
	logic [FETCH_W-1:0] stream_pc;
	logic [FETCH_W-1:0] region_base [8];
	logic [TAG_W-1:0]   conflict_tag [6];

	set_assoc_lru_cache_next_line_prefetch_top u_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.start                  (start),
		.busy                   (busy),
		.fetch_address          (fetch_address),
		.done                   (done),
		.hit                    (hit),
		.prefetch_useful        (prefetch_useful),
		.miss_total             (miss_total),
		.prefetch_success_total (prefetch_success_total),
		.prefetch_issue_total   (prefetch_issue_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				fetch_board.note_fetch(fetch_address);
			if (done)
				fetch_board.check_fetch({hit, prefetch_useful, miss_total,
					prefetch_success_total, prefetch_issue_total});
		end
	end

	// watchdog on cycles where no word moves either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_fetch(input logic [FETCH_W-1:0] a);
		start <= 1'b1;
		fetch_address <= a;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_fetches();
		start <= 1'b0;
		@(posedge clk);
		while (fetch_board.outstanding.size() != 0) @(posedge clk);
	endtask

	// mostly sequential code streams, some set conflicts, some noise
	function automatic logic [FETCH_W-1:0] pick_fetch_address();
		int mode;
		mode = $urandom_range(0, 19);
		if (mode <= 11) begin
			if ($urandom_range(0, 15) == 0)
				stream_pc = region_base[$urandom_range(0, 7)] + ($urandom_range(0, 63) << 2);
			else
				stream_pc = stream_pc + 4;
			return stream_pc;
		end else if (mode <= 15) begin
			return {conflict_tag[$urandom_range(0, 5)], IDX_W'($urandom_range(0, 3)),
				OFS_W'($urandom)};
		end else if (mode <= 17) begin
			return region_base[$urandom_range(0, 7)];
		end
		return $urandom;
	endfunction

	initial begin
		bit idle_on;
		fetch_board = new();
		foreach (region_base[i])
			region_base[i] = $urandom & ~32'h3;
		region_base[0] = 32'hFFFF_FF00;
		foreach (conflict_tag[i])
			conflict_tag[i] = TAG_W'($urandom);
		stream_pc = region_base[1];
		idle_on = 1'b1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_FETCHES[i])
			send_fetch(DIRECTED_FETCHES[i]);
		drain_fetches();

		for (int n = 0; n < RANDOM_FETCHES; n++) begin
			if (n % 64 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			if (n % 200 == 199)
				region_base[$urandom_range(1, 7)] = $urandom & ~32'h3;
			if (n == RANDOM_FETCHES / 2)
				drain_fetches();
			else if (idle_on && n < RANDOM_FETCHES - CALM_TAIL && $urandom_range(0, 4) == 0)
				idle_gap($urandom_range(1, 7));
			send_fetch(pick_fetch_address());
		end

		drain_fetches();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fetch_board.errors == 0 && fetch_board.outstanding.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/salpf_pkg.sv
src/salpf_set_store.sv
src/salpf_way_update.sv
src/set_assoc_lru_cache_next_line_prefetch_top.sv
sim/tb.sv
